/* design/sid_pkg.sv */
// Shared types and constants for the sharded ID register.
package sid_pkg;

    // First ID bit that feeds the shard select
    localparam int ID_SHIFT = 32;
    localparam int SLOT_W   = 8;
    localparam int CFG_W    = 3;

    // Register indexes on the configuration port (index = paddr[2])
    localparam logic REG_SHARD_BITS = 1'b0;

    typedef enum logic [2:0] {
        ST_FOUND      = 3'd0,
        ST_ADDED      = 3'd1,
        ST_NOT_FOUND  = 3'd2,
        ST_STORE_FULL = 3'd3,
        ST_SHARD_FULL = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_ORD,
        S_CMP,
        S_DECIDE,
        S_SHIFT,
        S_SHW,
        S_INS,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    latch;
        logic    ord_rd;
        logic    st_rd;
        logic    cmp_step;
        logic    ins_setup;
        logic    shift_rd;
        logic    shift_wr;
        logic    ins_wr;
        logic    res_set;
        t_status res_code;
        logic    out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_end;
        logic id_eq;
        logic id_gt;
        logic store_full;
        logic shard_full;
        logic shift_done;
        logic is_insert;
        logic out_free;
    } t_dp_sts;

endpackage

/* design/sid_if.sv */
// Request and response channel interfaces of the sharded ID register.
interface sid_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [63:0] user_id;

    modport source (output valid, output cmd, output user_id, input ready);
    modport sink   (input valid, input cmd, input user_id, output ready);
endinterface

interface sid_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink   (input valid, input status, input slot, output ready);
endinterface

/* design/sid_ram.sv */
// Generic simple dual-port RAM with registered read.
module sid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/sid_ctrl.sv */
// Sequencer for search, sorted insert and result hand-off.
module sid_ctrl
    import sid_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_state = i_sts.scan_end ? S_DECIDE : S_ORD;
            end
            S_ORD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_sts.id_eq) begin
                    n_state = S_DONE;
                end else if (i_sts.id_gt) begin
                    n_state = S_DECIDE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_DECIDE: begin
                if (i_sts.is_insert && !i_sts.store_full && !i_sts.shard_full) begin
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                n_state = i_sts.shift_done ? S_INS : S_SHW;
            end
            S_SHW: begin
                n_state = S_SHIFT;
            end
            S_INS: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.res_code = ST_FOUND;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.ord_rd = !i_sts.scan_end;
            end
            S_ORD: begin
                o_cmd.st_rd = 1'b1;
            end
            S_CMP: begin
                if (i_sts.id_eq) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = ST_FOUND;
                end else if (!i_sts.id_gt) begin
                    o_cmd.cmp_step = 1'b1;
                end
            end
            S_DECIDE: begin
                if (!i_sts.is_insert) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = ST_NOT_FOUND;
                end else if (i_sts.store_full) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = ST_STORE_FULL;
                end else if (i_sts.shard_full) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = ST_SHARD_FULL;
                end else begin
                    o_cmd.ins_setup = 1'b1;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_rd = !i_sts.shift_done;
            end
            S_SHW: begin
                o_cmd.shift_wr = 1'b1;
            end
            S_INS: begin
                o_cmd.ins_wr   = 1'b1;
                o_cmd.res_set  = 1'b1;
                o_cmd.res_code = ST_ADDED;
            end
            S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* design/sid_dp.sv */
// Datapath: item registers, ID store, sorted shard lists, fill counts, result register.
module sid_dp
    import sid_pkg::*;
#(
    parameter int MAX_IDS        = 256,
    parameter int MAX_SHARD_BITS = 4,
    parameter int SHARD_DEPTH    = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    input  logic [CFG_W-1:0] i_shard_bits,
    input  logic             i_item_cmd,
    input  logic [63:0]      i_item_id,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [2:0]       o_status,
    output logic [SLOT_W-1:0] o_slot
);

    localparam int SHARD_CNT = 1 << MAX_SHARD_BITS;
    localparam int SH_W      = (MAX_SHARD_BITS > 0) ? MAX_SHARD_BITS : 1;
    localparam int IDX_W     = $clog2(MAX_IDS);
    localparam int TOT_W     = $clog2(MAX_IDS + 1);
    localparam int FILL_W    = $clog2(SHARD_DEPTH + 1);
    localparam int ORD_DEPTH = SHARD_CNT * SHARD_DEPTH;
    localparam int ORD_AW    = (ORD_DEPTH > 1) ? $clog2(ORD_DEPTH) : 1;
    localparam logic [3:0]        MAXSB    = 4'(MAX_SHARD_BITS);
    localparam logic [TOT_W-1:0]  TOT_MAX  = TOT_W'(MAX_IDS);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(SHARD_DEPTH);

    logic                r_cmd_ins;
    logic [63:0]         r_id;
    logic [SH_W-1:0]     r_shard;
    logic [ORD_AW-1:0]   r_base;
    logic [FILL_W-1:0]   r_n;
    logic [FILL_W-1:0]   r_i;
    logic [FILL_W-1:0]   r_pos;
    logic [FILL_W-1:0]   r_j;
    logic [IDX_W-1:0]    r_idx;
    logic [TOT_W-1:0]    r_total;
    logic [FILL_W-1:0]   r_fill [SHARD_CNT];
    t_status             r_res;
    logic                r_out_valid;
    logic [2:0]          r_status;
    logic [SLOT_W-1:0]   r_slot;

    logic [3:0]          sat_bits;
    logic [SH_W-1:0]     sh_mask;
    logic [SH_W-1:0]     sh_sel;
    logic [SLOT_W+IDX_W-1:0] slot_ext;

    logic                st_we;
    logic [IDX_W-1:0]    st_waddr;
    logic [63:0]         st_rdata;
    logic                ord_we;
    logic                ord_re;
    logic [FILL_W-1:0]   wr_off;
    logic [FILL_W-1:0]   rd_off;
    logic [ORD_AW-1:0]   ord_waddr;
    logic [ORD_AW-1:0]   ord_raddr;
    logic [IDX_W-1:0]    ord_wdata;
    logic [IDX_W-1:0]    ord_rdata;

    // Shard select: saturate the field count, then mask the ID bits
    always_comb begin
        sat_bits = ({1'b0, i_shard_bits} > MAXSB) ? MAXSB : {1'b0, i_shard_bits};
        for (int b = 0; b < SH_W; b++) begin
            sh_mask[b] = (4'(b) < sat_bits);
        end
        sh_sel = i_item_id[ID_SHIFT +: SH_W] & sh_mask;
    end

    // Memory addressing
    assign st_we     = i_cmd.ins_setup;
    assign st_waddr  = r_total[IDX_W-1:0];
    assign ord_we    = i_cmd.shift_wr | i_cmd.ins_wr;
    assign ord_re    = i_cmd.ord_rd | i_cmd.shift_rd;
    assign wr_off    = i_cmd.shift_wr ? r_j : r_pos;
    assign rd_off    = i_cmd.ord_rd ? r_i : (r_j - 1'b1);
    assign ord_waddr = r_base + ORD_AW'(wr_off);
    assign ord_raddr = r_base + ORD_AW'(rd_off);
    assign ord_wdata = i_cmd.shift_wr ? ord_rdata : r_idx;

    sid_ram #(
        .WIDTH (64),
        .DEPTH (MAX_IDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (r_id),
        .i_re    (i_cmd.st_rd),
        .i_raddr (ord_rdata),
        .o_rdata (st_rdata)
    );

    sid_ram #(
        .WIDTH (IDX_W),
        .DEPTH (ORD_DEPTH)
    ) u_order (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_re    (ord_re),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    // Item and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd_ins <= i_item_cmd;
            r_id      <= i_item_id;
            r_shard   <= sh_sel;
            r_base    <= ORD_AW'(sh_sel * SHARD_DEPTH);
            r_n       <= r_fill[sh_sel];
            r_i       <= '0;
        end else if (i_cmd.cmp_step) begin
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.st_rd) begin
            r_idx <= ord_rdata;
        end else if (i_cmd.ins_setup) begin
            r_idx <= r_total[IDX_W-1:0];
        end
        if (i_cmd.ins_setup) begin
            r_pos <= r_i;
            r_j   <= r_n;
        end else if (i_cmd.shift_wr) begin
            r_j <= r_j - 1'b1;
        end
        if (i_cmd.res_set) begin
            r_res <= i_cmd.res_code;
        end
    end

    // Occupancy counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            for (int s = 0; s < SHARD_CNT; s++) begin
                r_fill[s] <= '0;
            end
        end else if (i_cmd.ins_wr) begin
            r_total         <= r_total + 1'b1;
            r_fill[r_shard] <= r_n + 1'b1;
        end
    end

    // Result register
    assign slot_ext = {{SLOT_W{1'b0}}, r_idx};

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status <= r_res;
            r_slot   <= (r_res == ST_FOUND || r_res == ST_ADDED) ?
                        slot_ext[SLOT_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_slot      = r_slot;

    always_comb begin
        o_sts            = '0;
        o_sts.scan_end   = (r_i == r_n);
        o_sts.id_eq      = (st_rdata == r_id);
        o_sts.id_gt      = (st_rdata > r_id);
        o_sts.store_full = (r_total >= TOT_MAX);
        o_sts.shard_full = (r_n >= FILL_MAX);
        o_sts.shift_done = (r_j == r_pos);
        o_sts.is_insert  = r_cmd_ins;
        o_sts.out_free   = !r_out_valid | i_out_ready;
    end

endmodule

/* design/sharded_id_register.sv */
// Top level of the sharded ID register: APB register, controller and datapath.
//
// The block hands out dense indices to 64-bit IDs. Each request transaction is
// a find (cmd 0) or an insert-if-absent (cmd 1) and yields exactly one response
// transaction with a status (found, added, not found, store full, shard full)
// and the 8-bit slot of the ID. The shard is ID bits [32 +: shard_bits], with
// shard_bits taken from register 0 and saturated to MAX_SHARD_BITS; change it
// only while the block is idle. Each shard holds up to SHARD_DEPTH indices kept
// sorted by ID, and the global store holds up to MAX_IDS IDs. One item is in
// work at a time. Each shard entry examined passes through SCAN (order read),
// ORD (the dependent ID store read) and CMP (compare). A find stops on a
// match, on a larger ID or at the end of the shard. An insert then moves
// each entry from the insert point up in the sorted list with a registered
// read, then the write one place up, and writes the new index.
// The block goes idle once the response is loaded, so a new request is taken
// while the previous response still waits in the output register; an item
// holds in its final state only while that earlier response is still stalled.
// No clearing pass runs after reset: only the fill counts, the ID total and
// the response valid flag of the datapath are reset, and stale memory is
// never read.
module sharded_id_register
    import sid_pkg::*;
#(
    parameter int MAX_IDS        = 256,
    parameter int MAX_SHARD_BITS = 4,
    parameter int SHARD_DEPTH    = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sid_req_if.sink       i_req,
    sid_rsp_if.source     o_rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [CFG_W-1:0] r_shard_bits;
    logic             cfg_wr;
    t_dp_cmd          dp_cmd;
    t_dp_sts          dp_sts;

    // Register write completes in the access phase; the port never waits
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_SHARD_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shard_bits <= '0;
        end else if (cfg_wr) begin
            r_shard_bits <= pwdata[CFG_W-1:0];
        end
    end

    // Reads return the register at index 0, zero elsewhere
    assign prdata = (paddr[2] == REG_SHARD_BITS) ?
                    {{(32 - CFG_W){1'b0}}, r_shard_bits} : '0;

    // Controller: sequences the shard walk, the insert shift and the hand-off
    sid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // Datapath: memories, counters and the response register
    sid_dp #(
        .MAX_IDS        (MAX_IDS),
        .MAX_SHARD_BITS (MAX_SHARD_BITS),
        .SHARD_DEPTH    (SHARD_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_shard_bits (r_shard_bits),
        .i_item_cmd   (i_req.cmd),
        .i_item_id    (i_req.user_id),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_status     (o_rsp.status),
        .o_slot       (o_rsp.slot)
    );

endmodule

/* design/sid_checker.sv */
// Port-level checks on the sharded ID register, bound to the top level.
module sid_checker
    import sid_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_out_status,
    input logic [7:0]  i_out_slot
);

    // Only found and added responses carry a slot
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status != ST_FOUND && i_out_status != ST_ADDED)
        |-> (i_out_slot == '0))
        else $error("slot nonzero on a miss or full response");

    // A stalled response holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready)
        |=> (i_out_valid && $stable(i_out_status) && $stable(i_out_slot)))
        else $error("response changed while stalled");

    // One item in work: no request is taken in the cycle after one is
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request accepted back to back");

    // Reset empties the response register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

endmodule

bind sharded_id_register sid_checker u_sid_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_status (o_rsp.status),
    .i_out_slot   (o_rsp.slot)
);
